>>> rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the scan sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, checked outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> rtl/core/asas_pkg.sv
// Types, constants and defaults of the ADC scan and average sequencer.
package asas_pkg;

  localparam int unsigned SAMPLE_W      = 10;
  localparam int unsigned READ_CH_W     = 3;
  localparam int unsigned SLOT_W        = 3;
  localparam int unsigned MUX_FIELD_W   = 5;
  localparam int unsigned MUX_TABLE_W   = 40;
  localparam int unsigned COUNT_W       = 4;
  localparam int unsigned SCNT_W        = 7;
  localparam int unsigned ACC_W         = 16;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 40;

  localparam int unsigned SAMPLE_SHIFT_DEF = 4;
  localparam int unsigned MAX_SLOTS_DEF    = 8;
  localparam int unsigned MUX_BITS_DEF     = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT = 2'd0,
    CFG_MUX_TABLE     = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    ACT_CONVERT = 1'b0,
    ACT_READ    = 1'b1
  } action_e;

  typedef struct packed {
    action_e               action;
    logic [SAMPLE_W-1:0]   sample;
    logic [READ_CH_W-1:0]  read_channel;
  } req_t;

  typedef struct packed {
    logic [MUX_FIELD_W-1:0] mux_select;
    logic [SLOT_W-1:0]      current_slot;
    logic [SAMPLE_W-1:0]    read_value;
    logic                   average_done;
  } rsp_t;

endpackage

>>> rtl/core/asas_req_if.sv
// Request channel of the scan sequencer: valid, ready and the request payload.
interface asas_req_if;
  import asas_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/asas_rsp_if.sv
// Response channel of the scan sequencer: valid, ready and the response payload.
interface asas_rsp_if;
  import asas_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/adc_scan_average_sequencer.sv
// Top level of the ADC scan sequencer with per-slot boxcar averaging.
//
//  Channel   Direction  Payload                                          Handshake
//  req_i     in         action, sample, read_channel                     valid/ready
//  rsp_o     out        mux_select, current_slot, read_value, avg_done   valid/ready
//  cfg       in         cfg_index_i, cfg_data_i                          cfg_we_i
//
// One request is taken every cycle while the output register is free or draining; its
// response is in the output register in the cycle after acceptance. The average table
// is a single-port-write memory with a registered read, used at most once per request.
// The output register can take a new response in the same cycle that its response is taken, so a
// stalled response only blocks new requests while it is still waiting.
// Reset clears the scan counters and the per-entry valid bits; an entry never stored
// reads as zero. There is no clearing pass over the table.
module adc_scan_average_sequencer #(
  parameter int unsigned SAMPLE_SHIFT = asas_pkg::SAMPLE_SHIFT_DEF,
  parameter int unsigned MAX_SLOTS    = asas_pkg::MAX_SLOTS_DEF,
  parameter int unsigned MUX_BITS     = asas_pkg::MUX_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [asas_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [asas_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  asas_req_if.sink                           req_i,
  asas_rsp_if.source                         rsp_o
);
  import asas_pkg::*;

  `include "assert_macros.svh"

  // Width of a table address; a single-slot build still gets one address bit.
  localparam int unsigned SlotIdxW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  // Sample count at which the next conversion closes the average.
  localparam logic [SCNT_W-1:0] FullCount = SCNT_W'(1 << SAMPLE_SHIFT);

  // Configuration registers.
  logic [COUNT_W-1:0]     chan_count_q;
  logic [MUX_TABLE_W-1:0] mux_table_q;

  // Scan state.
  logic [SCNT_W-1:0] count_q, count_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  // Average table and its valid bits.
  logic [SAMPLE_W-1:0]  avg_mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] avg_valid_q;
  logic [SAMPLE_W-1:0]  rd_data_q;

  // Output register.
  logic                rsp_valid_q;
  logic [MUX_BITS-1:0] mux_q;
  logic [SLOT_W-1:0]   rsp_slot_q;
  logic                done_q;
  logic                rd_hit_q;

  logic               req_fire;
  logic               conv_fire;
  logic               read_fire;
  logic               store;
  logic [COUNT_W-1:0] eff_count;
  logic [COUNT_W-1:0] next_slot;
  logic               read_in_range;
  logic [SlotIdxW-1:0] rd_idx;
  logic [SlotIdxW-1:0] wr_idx;

  // The output register can take a new response when empty or when drained this cycle.
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;
  assign conv_fire   = req_fire && (req_i.data.action == ACT_CONVERT);
  assign read_fire   = req_fire && (req_i.data.action == ACT_READ);
  assign store       = conv_fire && (count_q >= FullCount);

  // A channel count of zero scans one slot; anything past the table scans all of it.
  always_comb begin
    priority if (chan_count_q == '0) begin
      eff_count = COUNT_W'(1);
    end else if (chan_count_q > COUNT_W'(MAX_SLOTS)) begin
      eff_count = COUNT_W'(MAX_SLOTS);
    end else begin
      eff_count = chan_count_q;
    end
  end

  assign next_slot = {1'b0, slot_q} + COUNT_W'(1);

  // Accumulate until the count is full; the conversion after that closes the average
  // (its own sample is dropped) and steps to the next slot, wrapping past the last one.
  always_comb begin
    count_d = count_q;
    acc_d   = acc_q;
    slot_d  = slot_q;
    if (store) begin
      count_d = '0;
      acc_d   = '0;
      slot_d  = (next_slot >= eff_count) ? '0 : next_slot[SLOT_W-1:0];
    end else if (conv_fire) begin
      count_d = count_q + SCNT_W'(1);
      acc_d   = acc_q + ACC_W'(req_i.data.sample);
    end
  end

  assign read_in_range = {1'b0, req_i.data.read_channel} < COUNT_W'(MAX_SLOTS);
  assign rd_idx        = req_i.data.read_channel[SlotIdxW-1:0];
  assign wr_idx        = slot_q[SlotIdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_count_q <= COUNT_W'(1);
      mux_table_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CHANNEL_COUNT: chan_count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_MUX_TABLE:     mux_table_q  <= cfg_data_i[MUX_TABLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      acc_q       <= '0;
      slot_q      <= '0;
      avg_valid_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      acc_q   <= acc_d;
      slot_q  <= slot_d;
      if (store) begin
        avg_valid_q[wr_idx] <= 1'b1;
      end
      if (req_fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Table write on a store, registered read on a read request. Both sides never touch
  // the same edge for one request, and a store is visible to any later read.
  always_ff @(posedge clk_i) begin
    if (store) begin
      avg_mem[wr_idx] <= SAMPLE_W'(acc_q >> SAMPLE_SHIFT);
    end
    if (read_fire) begin
      rd_data_q <= avg_mem[rd_idx];
    end
  end

  // Response payload; the mux word belongs to the slot after any step this request made.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      mux_q      <= mux_table_q[MUX_FIELD_W*slot_d +: MUX_BITS];
      rsp_slot_q <= slot_d;
      done_q     <= store;
      rd_hit_q   <= read_fire && read_in_range && avg_valid_q[rd_idx];
    end
  end

  assign rsp_o.valid             = rsp_valid_q;
  assign rsp_o.data.mux_select   = MUX_FIELD_W'(mux_q);
  assign rsp_o.data.current_slot = rsp_slot_q;
  assign rsp_o.data.read_value   = rd_hit_q ? rd_data_q : '0;
  assign rsp_o.data.average_done = done_q;

  // A closing conversion leaves a cleared count and accumulator behind.
  `ASSERT_CLK(a_store_clears, store |=> (count_q == '0) && (acc_q == '0), "store did not clear")
  // A closing conversion is answered with the done flag set.
  `ASSERT_CLK(a_store_reports, store |=> rsp_valid_q && done_q, "store not reported")
  // The scan slot never leaves the table.
  `ASSERT_NEVER(a_slot_range, {1'b0, slot_q} >= COUNT_W'(MAX_SLOTS), "slot out of range")

endmodule

>>> test/asas_scan_checker.sv
// Scoreboard of the ADC scan sequencer: predicts each response and checks the response channel.
module asas_scan_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [asas_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [asas_pkg::CFG_DATA_W-1:0] cfg_data_i,
  asas_req_if                             req,
  asas_rsp_if                             rsp,
  output int unsigned                     mismatch_count_o,
  output int unsigned                     outstanding_o
);
  import asas_pkg::*;

  localparam int unsigned SHIFT = SAMPLE_SHIFT_DEF;
  localparam logic [SCNT_W-1:0] SAMPLES_PER_AVG = SCNT_W'(1 << SHIFT);

  // Shadow of the registers and of the scan state.
  logic [COUNT_W-1:0]     cfg_count;
  logic [MUX_TABLE_W-1:0] cfg_mux;
  logic [SCNT_W-1:0]      taken_cnt;
  logic [ACC_W-1:0]       sum_acc;
  logic [SLOT_W-1:0]      scan_slot;
  logic [SAMPLE_W-1:0]    slot_avg [MAX_SLOTS_DEF];

  rsp_t        scan_rsp_q [$];
  int unsigned mismatches = 0;

  assign mismatch_count_o = mismatches;

  // Advances the shadow scan by one request and returns the response it must produce.
  function automatic rsp_t next_scan_response(input req_t r);
    rsp_t               o;
    logic [COUNT_W-1:0] span;
    logic [COUNT_W-1:0] nxt;
    o = '0;
    if (r.action == ACT_CONVERT) begin
      if (taken_cnt < SAMPLES_PER_AVG) begin
        taken_cnt = taken_cnt + SCNT_W'(1);
        sum_acc   = sum_acc + ACC_W'(r.sample);
      end else begin
        // The sample that closes a window is dropped.
        slot_avg[scan_slot] = sum_acc[SHIFT +: SAMPLE_W];
        taken_cnt      = '0;
        sum_acc        = '0;
        o.average_done = 1'b1;
        if (cfg_count == '0) begin
          span = COUNT_W'(1);
        end else if (cfg_count > COUNT_W'(MAX_SLOTS_DEF)) begin
          span = COUNT_W'(MAX_SLOTS_DEF);
        end else begin
          span = cfg_count;
        end
        nxt       = {1'b0, scan_slot} + COUNT_W'(1);
        scan_slot = (nxt >= span) ? '0 : nxt[SLOT_W-1:0];
      end
    end else begin
      o.read_value = slot_avg[r.read_channel];
    end
    o.mux_select   = cfg_mux[scan_slot*MUX_FIELD_W +: MUX_FIELD_W];
    o.current_slot = scan_slot;
    return o;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t seen;
    rsp_t want;
    if (!rst_ni) begin
      cfg_count <= COUNT_W'(1);
      cfg_mux   <= '0;
      taken_cnt <= '0;
      sum_acc   <= '0;
      scan_slot <= '0;
      for (int k = 0; k < MAX_SLOTS_DEF; k++) begin
        slot_avg[k] <= '0;
      end
      scan_rsp_q.delete();
      outstanding_o <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        seen = rsp.data;
        if (scan_rsp_q.size() == 0) begin
          $error("response with no request pending: %p", seen);
          mismatches++;
        end else begin
          want = scan_rsp_q.pop_front();
          check_field("mux_select", want.mux_select, seen.mux_select);
          check_field("current_slot", want.current_slot, seen.current_slot);
          check_field("read_value", want.read_value, seen.read_value);
          check_field("average_done", want.average_done, seen.average_done);
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_CHANNEL_COUNT: cfg_count = cfg_data_i[COUNT_W-1:0];
          CFG_MUX_TABLE:     cfg_mux   = cfg_data_i[MUX_TABLE_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        scan_rsp_q.push_back(next_scan_response(req.data));
      end
      outstanding_o <= scan_rsp_q.size();
    end
  end

endmodule

>>> test/tb_adc_scan_average_sequencer.sv
// Testbench top of the ADC scan sequencer: clock, reset, request and register stimulus, verdict.
module tb_adc_scan_average_sequencer;
  import asas_pkg::*;

  // Rough number of requests in the whole run; the phase loop stops once it is reached.
  localparam int unsigned REQUEST_TARGET = 2000;
  // Generous bound on the run, in cycles.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // The register port decodes two index bits, but only two registers exist.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef enum int {
    MIX_RANDOM,
    MIX_FULL_SCALE,
    MIX_ZERO
  } sample_mix_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  steady;
  int unsigned           cycles;
  int unsigned           sent;
  int unsigned           fail_count;
  int unsigned           outstanding;

  asas_req_if req_ch ();
  asas_rsp_if rsp_ch ();

  adc_scan_average_sequencer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  asas_scan_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .req              (req_ch),
    .rsp              (rsp_ch),
    .mismatch_count_o (fail_count),
    .outstanding_o    (outstanding)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // The response side stalls at random, with a chance of about 23 in a hundred, except during
  // steady phases, where it always takes the response.
  always @(posedge clk_i) begin
    rsp_ch.ready <= steady || ($urandom_range(99) >= 23);
  end

  // Watchdog: a run that never drains ends here as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Writes one register. It is called at a clock edge and returns at a later edge with the
  // write enable already lowered, so back-to-back writes never assign it twice in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offers one request and returns at the edge where it is accepted. Before the request the
  // sender may idle for a random number of cycles, with noise on the payload.
  task automatic send_request(input req_t r);
    while (!steady && $urandom_range(99) < 23) begin
      req_ch.valid <= 1'b0;
      req_ch.data  <= req_t'($urandom());
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk_i); while (!req_ch.ready);
    sent++;
  endtask

  // Lowers valid and waits until every response has been taken, plus a short settling time,
  // so that a register write that follows finds the block idle.
  task automatic wait_for_responses();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (3) @(posedge clk_i);
  endtask

  function automatic req_t make_request(input action_e act, input int unsigned smp,
                                        input int unsigned ch);
    req_t r;
    r.action       = act;
    r.sample       = smp[SAMPLE_W-1:0];
    r.read_channel = ch[READ_CH_W-1:0];
    return r;
  endfunction

  // Mostly conversions, so that the averaging windows close and the scan moves; about one
  // request in seven reads back a stored average.
  function automatic req_t random_request(input sample_mix_e mix);
    action_e     act;
    int unsigned smp;
    act = ($urandom_range(99) < 15) ? ACT_READ : ACT_CONVERT;
    case (mix)
      MIX_FULL_SCALE: smp = 1023;
      MIX_ZERO:       smp = 0;
      default: begin
        case ($urandom_range(9))
          0:       smp = 0;
          1:       smp = 1023;
          default: smp = $urandom_range(1023);
        endcase
      end
    endcase
    return make_request(act, smp, $urandom_range(7));
  endfunction

  // A random 40-bit value; the cast drops the upper 24 bits of the first word.
  function automatic logic [CFG_DATA_W-1:0] random_word();
    return CFG_DATA_W'({$urandom(), $urandom()});
  endfunction

  initial begin
    int unsigned        phase;
    int unsigned        batch;
    logic [COUNT_W-1:0] count_val;
    sample_mix_e        mix;

    rst_ni       <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    steady       <= 1'b0;
    sent = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, with the reset settings of one channel and an all-zero mux table.
    // Every table entry reads zero before anything has been stored.
    for (int k = 0; k < MAX_SLOTS_DEF; k++) begin
      send_request(make_request(ACT_READ, 1023, k));
    end
    // A full window of full-scale samples; the closing conversion carries zero and is
    // dropped, so the stored average is full scale and the single-channel scan stays on
    // slot zero.
    for (int k = 0; k < 16; k++) begin
      send_request(make_request(ACT_CONVERT, 1023, 7));
    end
    send_request(make_request(ACT_CONVERT, 0, 0));
    send_request(make_request(ACT_READ, 0, 0));
    wait_for_responses();

    // Writes to the unused indexes must leave both registers alone, and a channel count
    // wider than four bits is cut to its low bits.
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, random_word());
    write_reg(CFG_CHANNEL_COUNT, {36'hF_FFFF_FFFF, 4'd8});
    write_reg(CFG_MUX_TABLE, random_word());

    // Lowering the count below the slot in progress: walk the full scan up to slot five
    // without any idling, then shrink the list to two channels. Slot five keeps sampling
    // and its next advance wraps the scan to slot zero.
    steady <= 1'b1;
    for (int k = 0; k < 5 * 17; k++) begin
      send_request(make_request(ACT_CONVERT, $urandom_range(1023), $urandom_range(7)));
    end
    wait_for_responses();
    write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(2));
    for (int k = 0; k < 40; k++) begin
      send_request(random_request(MIX_RANDOM));
    end
    wait_for_responses();
    steady <= 1'b0;
    @(posedge clk_i);

    // Random phases: each one picks new settings while the block is idle, then streams a
    // batch of requests. Every sixth phase runs without idling on either side.
    phase = 0;
    while (sent < REQUEST_TARGET) begin
      phase++;
      steady <= (phase % 6 == 3);
      if (phase % 4 == 0) begin
        // Extremes of the channel count, including zero and values past the slot count.
        case ($urandom_range(3))
          0:       count_val = COUNT_W'(0);
          1:       count_val = COUNT_W'(1);
          2:       count_val = COUNT_W'(8);
          default: count_val = COUNT_W'(15);
        endcase
      end else if (phase % 4 == 1) begin
        count_val = COUNT_W'($urandom_range(15));
      end else begin
        count_val = COUNT_W'($urandom_range(1, 8));
      end
      write_reg(CFG_CHANNEL_COUNT, (random_word() << COUNT_W) | CFG_DATA_W'(count_val));
      case (phase % 5)
        1:       write_reg(CFG_MUX_TABLE, '0);
        2:       write_reg(CFG_MUX_TABLE, '1);
        default: write_reg(CFG_MUX_TABLE, random_word());
      endcase
      if ($urandom_range(3) == 0) begin
        write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, random_word());
      end
      case ($urandom_range(5))
        0:       mix = MIX_FULL_SCALE;
        1:       mix = MIX_ZERO;
        default: mix = MIX_RANDOM;
      endcase
      batch = $urandom_range(30, 200);
      for (int k = 0; k < batch; k++) begin
        send_request(random_request(mix));
      end
      wait_for_responses();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
